@@ rtl/ssrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Storage span run coalescer: shared definitions
// Descriptor kind codes, split constants and the flush request that passes
// from the classifying front end to the span emitter.
// ----------------------------------------------------------------------------
package ssrc_pkg;

    // Descriptor kinds.
    localparam logic [2:0] KIND_RESIDENT_RAW  = 3'd0;
    localparam logic [2:0] KIND_PARTIAL_RAW   = 3'd1;
    localparam logic [2:0] KIND_MISSING_COMP  = 3'd2;
    localparam logic [2:0] KIND_PARTIAL_COMP  = 3'd3;
    localparam logic [2:0] KIND_DEPENDENCY    = 3'd4;

    // Restore modes.
    localparam logic MODE_MISSING  = 1'b0;
    localparam logic MODE_RESERVED = 1'b1;

    // The first span of a plan is split when the run holds at least this many blocks.
    localparam logic [31:0] SPLIT_MIN_BLOCKS = 32'd4;
    // Block size used when the register holds zero, and the register reset.
    localparam logic [31:0] DEFAULT_BLOCK_SIZE = 32'h0000_4000;

    // Flush request queue.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // One run to be emitted as one span, or as two when split is set.
    typedef struct packed {
        logic [63:0] start;
        logic [31:0] bytes;
        logic [31:0] lead_blocks;
        logic        split;
        logic        mode;
        logic        last;
    } flush_req_t;

endpackage

@@ rtl/ssrc_front.sv @@
// ----------------------------------------------------------------------------
// Storage span run coalescer: front end
// Accepts descriptors, tracks the open run and issues flush requests.
// ----------------------------------------------------------------------------
module ssrc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [95:0]         s_tdata,   // stored offset[63:0], stored size[95:64]
    input  logic [2:0]          s_tuser,   // descriptor_kind[2:0]
    input  logic                s_tlast,   // end_of_plan
    input  logic                q_full,
    output logic                q_push,
    output ssrc_pkg::flush_req_t q_push_req
);

    logic [63:0] run_start_reg,  run_start_next;
    logic [31:0] run_bytes_reg,  run_bytes_next;
    logic [31:0] run_blocks_reg, run_blocks_next;
    logic        run_mode_reg,   run_mode_next;
    logic        any_emit_reg,   any_emit_next;
    logic        pend_valid_reg, pend_valid_next;
    ssrc_pkg::flush_req_t pend_req_reg, pend_req_next;

    logic        accept;
    logic [63:0] in_offset;
    logic [31:0] in_size;
    logic        is_join;
    logic        in_mode;
    logic        has_run;
    logic        brk;
    logic        flush_a;
    logic        flush_b;
    logic [63:0] mid_start;
    logic [31:0] mid_bytes;
    logic [31:0] mid_blocks;
    logic        mid_mode;
    logic        any_mid;
    ssrc_pkg::flush_req_t req_a;
    ssrc_pkg::flush_req_t req_b;

    assign in_offset = s_tdata[63:0];
    assign in_size   = s_tdata[95:64];

    // A second request from the same descriptor waits in the pending slot.
    assign s_tready = !pend_valid_reg && !q_full;
    assign accept   = s_tvalid && s_tready;

    // Classify the descriptor against the open run.
    always_comb begin
        is_join = s_tuser inside {ssrc_pkg::KIND_MISSING_COMP, ssrc_pkg::KIND_PARTIAL_COMP,
                                  ssrc_pkg::KIND_DEPENDENCY};
        in_mode = (s_tuser == ssrc_pkg::KIND_PARTIAL_COMP) ? ssrc_pkg::MODE_RESERVED
                                                           : ssrc_pkg::MODE_MISSING;
        has_run = (run_blocks_reg != 32'd0);
        brk     = !has_run || (run_start_reg + {32'd0, run_bytes_reg} != in_offset)
                  || (run_mode_reg != in_mode);
        flush_a = has_run && (!is_join || brk);

        if (is_join && brk) begin
            mid_start  = in_offset;
            mid_bytes  = in_size;
            mid_blocks = 32'd1;
            mid_mode   = in_mode;
        end else if (is_join) begin
            mid_start  = run_start_reg;
            mid_bytes  = run_bytes_reg + in_size;
            mid_blocks = run_blocks_reg + 32'd1;
            mid_mode   = run_mode_reg;
        end else begin
            mid_start  = 64'd0;
            mid_bytes  = 32'd0;
            mid_blocks = 32'd0;
            mid_mode   = ssrc_pkg::MODE_MISSING;
        end

        any_mid = any_emit_reg || flush_a;
        flush_b = s_tlast && (mid_blocks != 32'd0);

        // Flush of the run that the descriptor breaks.
        req_a.start       = run_start_reg;
        req_a.bytes       = run_bytes_reg;
        req_a.lead_blocks = run_blocks_reg - (run_blocks_reg >> 1);
        req_a.split       = !any_emit_reg && (run_blocks_reg >= ssrc_pkg::SPLIT_MIN_BLOCKS);
        req_a.mode        = run_mode_reg;
        req_a.last        = !flush_b;

        // Flush at the end of the plan.
        req_b.start       = mid_start;
        req_b.bytes       = mid_bytes;
        req_b.lead_blocks = mid_blocks - (mid_blocks >> 1);
        req_b.split       = !any_mid && (mid_blocks >= ssrc_pkg::SPLIT_MIN_BLOCKS);
        req_b.mode        = mid_mode;
        req_b.last        = 1'b1;
    end

    // Request issue and state update.
    always_comb begin
        run_start_next  = run_start_reg;
        run_bytes_next  = run_bytes_reg;
        run_blocks_next = run_blocks_reg;
        run_mode_next   = run_mode_reg;
        any_emit_next   = any_emit_reg;
        pend_valid_next = pend_valid_reg;
        pend_req_next   = pend_req_reg;
        q_push          = 1'b0;
        q_push_req      = req_a;

        if (pend_valid_reg) begin
            q_push_req = pend_req_reg;
            if (!q_full) begin
                q_push          = 1'b1;
                pend_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (flush_a) begin
                q_push     = 1'b1;
                q_push_req = req_a;
                if (flush_b) begin
                    pend_valid_next = 1'b1;
                    pend_req_next   = req_b;
                end
            end else if (flush_b) begin
                q_push     = 1'b1;
                q_push_req = req_b;
            end

            if (s_tlast) begin
                run_start_next  = 64'd0;
                run_bytes_next  = 32'd0;
                run_blocks_next = 32'd0;
                run_mode_next   = ssrc_pkg::MODE_MISSING;
                any_emit_next   = 1'b0;
            end else begin
                run_start_next  = mid_start;
                run_bytes_next  = mid_bytes;
                run_blocks_next = mid_blocks;
                run_mode_next   = mid_mode;
                any_emit_next   = any_mid;
            end
        end
    end

    // Run state and pending flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_start_reg  <= 64'd0;
            run_bytes_reg  <= 32'd0;
            run_blocks_reg <= 32'd0;
            run_mode_reg   <= ssrc_pkg::MODE_MISSING;
            any_emit_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            run_start_reg  <= run_start_next;
            run_bytes_reg  <= run_bytes_next;
            run_blocks_reg <= run_blocks_next;
            run_mode_reg   <= run_mode_next;
            any_emit_reg   <= any_emit_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // Pending request payload.
    always_ff @(posedge aclk) begin
        pend_req_reg <= pend_req_next;
    end

endmodule

@@ rtl/ssrc_queue.sv @@
// ----------------------------------------------------------------------------
// Storage span run coalescer: flush request queue
// A short first-in first-out buffer between the front end and the emitter.
// ----------------------------------------------------------------------------
module ssrc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  ssrc_pkg::flush_req_t push_req,
    input  logic                 pop,
    output ssrc_pkg::flush_req_t head_req,
    output logic                 full,
    output logic                 empty
);

    ssrc_pkg::flush_req_t entry_reg [ssrc_pkg::QUEUE_DEPTH];

    logic [ssrc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ssrc_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ssrc_pkg::QUEUE_CNT_W-1:0] count_reg,  count_next;

    localparam logic [ssrc_pkg::QUEUE_CNT_W-1:0] CountFull =
        ssrc_pkg::QUEUE_CNT_W'(ssrc_pkg::QUEUE_DEPTH);
    localparam logic [ssrc_pkg::QUEUE_PTR_W-1:0] PtrLast =
        ssrc_pkg::QUEUE_PTR_W'(ssrc_pkg::QUEUE_DEPTH - 1);

    assign full     = (count_reg == CountFull);
    assign empty    = (count_reg == '0);
    assign head_req = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0
                                                  : wr_ptr_reg + ssrc_pkg::QUEUE_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0
                                                  : rd_ptr_reg + ssrc_pkg::QUEUE_PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + ssrc_pkg::QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - ssrc_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

@@ rtl/ssrc_back.sv @@
// ----------------------------------------------------------------------------
// Storage span run coalescer: span emitter
// Turns flush requests into spans, splitting the first long run of a plan.
// ----------------------------------------------------------------------------
module ssrc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [31:0]          blk_bytes,
    input  logic                 q_empty,
    input  ssrc_pkg::flush_req_t q_head_req,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [95:0]          m_tdata,   // span start[63:0], span length[95:64]
    output logic                 m_tuser,   // restore_mode
    output logic                 m_tlast    // last_of_item
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_LEAD = 2'd2;
    localparam logic [1:0] ST_REST = 2'd3;

    logic [1:0]  state_reg, state_next;
    ssrc_pkg::flush_req_t req_reg, req_next;
    logic [31:0] lead_reg, lead_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_offset_reg, out_offset_next;
    logic [31:0] out_size_reg, out_size_next;
    logic        out_mode_reg, out_mode_next;
    logic        out_last_reg, out_last_next;

    logic        out_free;
    logic        out_load;
    logic [31:0] bs_eff;

    assign out_free = !out_valid_reg || m_tready;
    assign bs_eff   = (blk_bytes == 32'd0) ? ssrc_pkg::DEFAULT_BLOCK_SIZE : blk_bytes;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_size_reg, out_offset_reg};
    assign m_tuser  = out_mode_reg;
    assign m_tlast  = out_last_reg;

    // Emit sequencer: a plain run goes straight to the output register, a split
    // run passes through a multiply state for the lead size and then gives two spans.
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        lead_next       = lead_reg;
        out_offset_next = out_offset_reg;
        out_size_next   = out_size_reg;
        out_mode_next   = out_mode_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        q_pop           = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty && out_free) begin
                    q_pop = 1'b1;
                    if (q_head_req.split) begin
                        req_next   = q_head_req;
                        state_next = ST_MUL;
                    end else begin
                        out_load        = 1'b1;
                        out_offset_next = q_head_req.start;
                        out_size_next   = q_head_req.bytes;
                        out_mode_next   = q_head_req.mode;
                        out_last_next   = q_head_req.last;
                    end
                end
            end
            ST_MUL: begin
                lead_next  = bs_eff * req_reg.lead_blocks;
                state_next = ST_LEAD;
            end
            ST_LEAD: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_offset_next = req_reg.start;
                    out_size_next   = lead_reg;
                    out_mode_next   = req_reg.mode;
                    out_last_next   = 1'b0;
                    state_next      = ST_REST;
                end
            end
            ST_REST: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    out_offset_next = req_reg.start + {32'd0, lead_reg};
                    out_size_next   = req_reg.bytes - lead_reg;
                    out_mode_next   = req_reg.mode;
                    out_last_next   = req_reg.last;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        lead_reg       <= lead_next;
        out_offset_reg <= out_offset_next;
        out_size_reg   <= out_size_next;
        out_mode_reg   <= out_mode_next;
        out_last_reg   <= out_last_next;
    end

endmodule

@@ rtl/storage_span_run_coalescer_top.sv @@
// Coalesces read-plan descriptors into storage availability spans. A descriptor
// is taken when the queue is not full and no request is pending; one that both
// breaks a run and ends the plan leaves its second flush request in a pending
// slot that holds off the next descriptor. Flush requests wait in a four-entry
// queue for the span emitter, which loads a plain span straight into its output
// register and takes the split first run of a plan in steps (taking the request,
// lead size multiply, then two spans), waiting while the output is stalled. The
// block size register may be written only while no descriptor is in flight.
// ----------------------------------------------------------------------------
// Storage span run coalescer: top level
// Joins contiguous compressed and dependency descriptors into spans.
// ----------------------------------------------------------------------------
module storage_span_run_coalescer_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,   // bytes per block for the first-run split
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,       // stored offset[63:0], stored size[95:64]
    input  logic [2:0]  s_tuser,       // descriptor_kind[2:0]
    input  logic        s_tlast,       // end_of_plan
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,       // span start[63:0], span length[95:64]
    output logic        m_tuser,       // restore_mode
    output logic        m_tlast        // last_of_item
);

    logic [31:0] blk_bytes_reg;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    ssrc_pkg::flush_req_t q_push_req;
    ssrc_pkg::flush_req_t q_head_req;

    // Block size register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_bytes_reg <= ssrc_pkg::DEFAULT_BLOCK_SIZE;
        end else if (cfg_wr_en) begin
            blk_bytes_reg <= cfg_wr_data;
        end
    end

    ssrc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_push_req (q_push_req)
    );

    ssrc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_req (q_push_req),
        .pop      (q_pop),
        .head_req (q_head_req),
        .full     (q_full),
        .empty    (q_empty)
    );

    ssrc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .blk_bytes  (blk_bytes_reg),
        .q_empty    (q_empty),
        .q_head_req (q_head_req),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // The front end never writes a request into a full queue.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("flush request written into a full queue");

    // The emitter never takes a request from an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("flush request taken from an empty queue");

    // A span held back by the receiver stays unchanged until it is taken.
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                     && $stable(m_tlast)))
        else $error("stalled span changed before it was taken");

endmodule

@@ sim/ssrc_span_checker.sv @@
// ----------------------------------------------------------------------------
// Storage span run coalescer: span checker
// Watches the descriptor and span channels, predicts the spans that each
// accepted descriptor request causes and compares every accepted span with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ssrc_span_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,       // stored offset[63:0], stored size[95:64]
    input  logic [2:0]  s_tuser,       // descriptor_kind[2:0]
    input  logic        s_tlast,       // end_of_plan
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,       // span start[63:0], span length[95:64]
    input  logic        m_tuser,       // restore_mode
    input  logic        m_tlast,       // last_of_item
    output int          fail_count,
    output int          spans_outstanding
);

    typedef struct packed {
        logic [63:0] offset;
        logic [31:0] size;
        logic        mode;
        logic        last;
    } span_t;

    span_t       expected_spans[$];
    span_t       item_spans[$];
    span_t       got;
    span_t       want;

    // Predicted copy of the block's register and run state.
    logic [31:0] blk_bytes;
    logic [63:0] run_start;
    logic [31:0] run_bytes;
    logic [31:0] run_blocks;
    logic        run_mode;
    logic        plan_has_span;

    function automatic void add_span(input logic [63:0] off, input logic [31:0] sz);
        span_t s;
        s.offset = off;
        s.size   = sz;
        s.mode   = run_mode;
        s.last   = 1'b0;
        item_spans = {item_spans, s};
    endfunction

    // Closes the open run: one span, or two when it is the first long run of a plan.
    function automatic void close_run();
        logic [31:0] bs;
        logic [31:0] lead;
        if (run_blocks != 32'd0) begin
            if (!plan_has_span && run_blocks >= ssrc_pkg::SPLIT_MIN_BLOCKS) begin
                bs   = (blk_bytes != 32'd0) ? blk_bytes : ssrc_pkg::DEFAULT_BLOCK_SIZE;
                lead = bs * (run_blocks - run_blocks / 32'd2);
                add_span(run_start, lead);
                add_span(run_start + {32'd0, lead}, run_bytes - lead);
            end else begin
                add_span(run_start, run_bytes);
            end
            plan_has_span = 1'b1;
        end
        run_start  = '0;
        run_bytes  = '0;
        run_blocks = '0;
        run_mode   = ssrc_pkg::MODE_MISSING;
    endfunction

    // Works out the spans caused by one descriptor request and queues them.
    function automatic void predict_spans(input logic [2:0] kind, input logic [63:0] off,
                                          input logic [31:0] sz, input logic eop);
        logic  mode;
        item_spans.delete();
        if (kind == ssrc_pkg::KIND_MISSING_COMP || kind == ssrc_pkg::KIND_PARTIAL_COMP ||
            kind == ssrc_pkg::KIND_DEPENDENCY) begin
            mode = (kind == ssrc_pkg::KIND_PARTIAL_COMP) ? ssrc_pkg::MODE_RESERVED
                                                         : ssrc_pkg::MODE_MISSING;
            if (run_blocks == 32'd0 || run_start + {32'd0, run_bytes} != off ||
                run_mode != mode) begin
                close_run();
                run_start  = off;
                run_bytes  = sz;
                run_blocks = 32'd1;
                run_mode   = mode;
            end else begin
                run_bytes  = run_bytes + sz;
                run_blocks = run_blocks + 32'd1;
            end
        end else begin
            close_run();
        end
        if (eop) begin
            close_run();
            plan_has_span = 1'b0;
        end
        if (item_spans.size() > 0)
            item_spans[item_spans.size() - 1].last = 1'b1;
        expected_spans = {expected_spans, item_spans};
    endfunction

    function automatic void report_field(input string field, input logic [63:0] exp_val,
                                        input logic [63:0] act_val);
        fail_count++;
        $display("%0t: span %s mismatch, expected %h, actual %h",
                 $time, field, exp_val, act_val);
    endfunction

    // Spans are compared before the new request is predicted: no span can leave
    // in the cycle its descriptor is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_spans.delete();
            blk_bytes     = ssrc_pkg::DEFAULT_BLOCK_SIZE;
            run_start     = '0;
            run_bytes     = '0;
            run_blocks    = '0;
            run_mode      = ssrc_pkg::MODE_MISSING;
            plan_has_span = 1'b0;
            fail_count    = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.offset = m_tdata[63:0];
                got.size   = m_tdata[95:64];
                got.mode   = m_tuser;
                got.last   = m_tlast;
                if (expected_spans.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected span, expected none, actual %h", $time, got);
                end else begin
                    want = expected_spans.pop_front();
                    if (got.offset !== want.offset)
                        report_field("offset", want.offset, got.offset);
                    if (got.size !== want.size)
                        report_field("size", {32'd0, want.size}, {32'd0, got.size});
                    if (got.mode !== want.mode)
                        report_field("mode", {63'd0, want.mode}, {63'd0, got.mode});
                    if (got.last !== want.last)
                        report_field("last", {63'd0, want.last}, {63'd0, got.last});
                end
            end
            if (s_tvalid && s_tready)
                predict_spans(s_tuser, s_tdata[63:0], s_tdata[95:64], s_tlast);
            if (cfg_wr_en)
                blk_bytes = cfg_wr_data;
        end
        spans_outstanding = expected_spans.size();
    end

endmodule

@@ sim/storage_span_run_coalescer_top_tb.sv @@
// ----------------------------------------------------------------------------
// Storage span run coalescer: testbench top
// Drives directed and random read plans through the block under three idling
// patterns and several block sizes; the span checker predicts and compares.
// ----------------------------------------------------------------------------
module storage_span_run_coalescer_top_tb;

    // Kinds without a use of their own; the block treats them as raw.
    localparam logic [2:0] KIND_SPARE_LO  = 3'd5;
    localparam logic [2:0] KIND_SPARE_MID = 3'd6;
    localparam logic [2:0] KIND_SPARE_HI  = 3'd7;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 100;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] offset;
        logic [31:0] size;
        logic        eop;
    } desc_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int          fail_count;
    int          spans_outstanding;
    int          sender_idle_pct;
    int          sink_idle_pct;
    logic [63:0] chain_off;

    storage_span_run_coalescer_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    ssrc_span_checker span_check (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .fail_count        (fail_count),
        .spans_outstanding (spans_outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The span receiver stalls at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    function automatic logic [63:0] pick_offset();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return {32'hFFFF_FFFF, $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000)};
            default: return {32'd0, $urandom_range(32'h00FF_FFFF)};
        endcase
    endfunction

    function automatic logic [31:0] pick_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return 32'd0;
        else if (pick < 20)
            return $urandom;
        else if (pick < 28)
            return $urandom_range(32'hFFFF_FFFF, 32'hFFFF_F000);
        return $urandom_range(32'h0001_0000, 32'd1);
    endfunction

    // Offers one descriptor request, idling first at random, and waits for it to be taken.
    task automatic send_desc(input logic [2:0] kind, input logic [63:0] off,
                             input logic [31:0] sz, input logic eop);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {sz, off};
        s_tlast  <= eop;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_group_bytes(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Holds the sender off until every predicted span has come, then lets
    // any descriptor that causes no span settle.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (spans_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_directed();
        // Raw kinds on an empty run emit nothing.
        send_desc(ssrc_pkg::KIND_RESIDENT_RAW, 64'd0, 32'd0, 1'b0);
        send_desc(ssrc_pkg::KIND_PARTIAL_RAW, '1, '1, 1'b0);
        // First run of four blocks, closed by a raw kind, is split.
        for (int i = 0; i < 4; i++)
            send_desc(ssrc_pkg::KIND_MISSING_COMP, 64'h1000 + 64'h4000 * i, 32'h4000, 1'b0);
        send_desc(ssrc_pkg::KIND_RESIDENT_RAW, 64'd0, 32'd0, 1'b0);
        // Reserved run closed by a change of mode, then a gap in contiguity.
        send_desc(ssrc_pkg::KIND_PARTIAL_COMP, 64'h10_0000, 32'h200, 1'b0);
        send_desc(ssrc_pkg::KIND_PARTIAL_COMP, 64'h10_0200, 32'h300, 1'b0);
        send_desc(ssrc_pkg::KIND_DEPENDENCY, 64'h10_0500, 32'd0, 1'b0);
        send_desc(ssrc_pkg::KIND_MISSING_COMP, 64'h10_0500, 32'h10, 1'b0);
        send_desc(ssrc_pkg::KIND_MISSING_COMP, 64'h20_0000, 32'h40, 1'b0);
        // Unused kinds close the run like raw kinds; the last ends the plan.
        send_desc(KIND_SPARE_LO, 64'd0, 32'd0, 1'b0);
        send_desc(KIND_SPARE_MID, 64'd0, 32'd0, 1'b0);
        send_desc(KIND_SPARE_HI, 64'd0, 32'd0, 1'b1);
        // Split whose second size wraps, then a mode change that ends the plan:
        // three spans from one request.
        for (int i = 0; i < 4; i++)
            send_desc(ssrc_pkg::KIND_DEPENDENCY, 64'h3000 + 64'h1000 * i, 32'h1000, 1'b0);
        send_desc(ssrc_pkg::KIND_PARTIAL_COMP, 64'h7000, 32'h800, 1'b1);
        // Offsets and byte counts that wrap.
        send_desc(ssrc_pkg::KIND_MISSING_COMP, 64'hFFFF_FFFF_FFFF_FFF0, 32'h10, 1'b0);
        send_desc(ssrc_pkg::KIND_DEPENDENCY, 64'd0, 32'hFFFF_FFFF, 1'b0);
        send_desc(ssrc_pkg::KIND_MISSING_COMP, 64'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_desc(ssrc_pkg::KIND_MISSING_COMP, 64'h1_FFFF_FFFE, 32'h20, 1'b1);
        // End of plan with nothing open, then a single-block plan.
        send_desc(ssrc_pkg::KIND_RESIDENT_RAW, 64'd0, 32'd0, 1'b1);
        send_desc(ssrc_pkg::KIND_DEPENDENCY, '1, 32'h1234, 1'b1);
    endtask

    // Random plans: mostly well-formed runs, with raw kinds, broken runs and noise.
    task automatic run_random(input int item_budget);
        desc_t plan[$];
        desc_t d;
        int    sent;
        int    pick;
        int    len;
        logic  reserved;
        sent = 0;
        while (sent < item_budget) begin
            plan.delete();
            repeat ($urandom_range(4, 1)) begin
                pick = $urandom_range(99);
                d.eop = 1'b0;
                if (pick < 60) begin
                    // Contiguous blocks of one restore mode.
                    reserved = 1'($urandom_range(1));
                    len = $urandom_range(7, 1);
                    if ($urandom_range(3) != 0)
                        chain_off = pick_offset();
                    repeat (len) begin
                        if (reserved)
                            d.kind = ssrc_pkg::KIND_PARTIAL_COMP;
                        else
                            d.kind = $urandom_range(1) ? ssrc_pkg::KIND_MISSING_COMP
                                                       : ssrc_pkg::KIND_DEPENDENCY;
                        d.offset  = chain_off;
                        d.size    = pick_size();
                        chain_off = d.offset + {32'd0, d.size};
                        plan = {plan, d};
                    end
                end else if (pick < 75) begin
                    case ($urandom_range(2))
                        0: d.kind = ssrc_pkg::KIND_RESIDENT_RAW;
                        1: d.kind = ssrc_pkg::KIND_PARTIAL_RAW;
                        default: d.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
                    endcase
                    d.offset = pick_offset();
                    d.size   = pick_size();
                    plan = {plan, d};
                end else if (pick < 90) begin
                    // A compressed or dependency block just off the end of the chain.
                    d.kind    = 3'($urandom_range(ssrc_pkg::KIND_DEPENDENCY,
                                                  ssrc_pkg::KIND_MISSING_COMP));
                    d.offset  = chain_off + 64'($urandom_range(64, 1));
                    d.size    = pick_size();
                    chain_off = d.offset + {32'd0, d.size};
                    plan = {plan, d};
                end else begin
                    d.kind   = 3'($urandom_range(7));
                    d.offset = pick_offset();
                    d.size   = pick_size();
                    d.eop    = 1'($urandom_range(1));
                    plan = {plan, d};
                end
            end
            if ($urandom_range(99) < 85)
                plan[plan.size() - 1].eop = 1'b1;
            foreach (plan[i])
                send_desc(plan[i].kind, plan[i].offset, plan[i].size, plan[i].eop);
            sent += plan.size();
        end
    endtask

    // Stimulus: reset, directed plans, then three random phases.
    initial begin
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = ssrc_pkg::KIND_RESIDENT_RAW;
        s_tlast         = 1'b0;
        sender_idle_pct = 18;
        sink_idle_pct   = 48;
        chain_off       = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A zero block size falls back to the default.
        write_group_bytes(32'd0);
        run_directed();
        wait_for_drain();

        write_group_bytes(32'd1);
        run_random(RANDOM_ITEMS);
        wait_for_drain();

        sender_idle_pct = 48;
        sink_idle_pct   = 18;
        write_group_bytes(32'hFFFF_FFFF);
        run_random(RANDOM_ITEMS);
        wait_for_drain();

        sender_idle_pct = 0;
        sink_idle_pct   = 0;
        write_group_bytes($urandom);
        run_random(RANDOM_ITEMS);
        wait_for_drain();

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog on the whole run.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
